/* sv/ptts_pkg.sv */
// Shared constants and types for the periodic task tick scheduler.
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
    localparam int MAX_RESULTS = 8;
    localparam int REP_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 16;
    localparam int ENTRY_W     = 2 * TIME_W;
    localparam int MODE_W      = 3;
    localparam int IDX_W       = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_CREATE  = 3'd1,
        MODE_SUSPEND = 3'd2,
        MODE_RESUME  = 3'd3,
        MODE_DELETE  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_RESP
    } state_t;

endpackage

/* sv/periodic_task_tick_scheduler.sv */
// Top level: task slot table with per-tick walk over a period/countdown RAM.
//
//  channel | dir | beat fields
//  s_*     | in  | tdata: mode[2:0] task_index[5:3] period[21:6] first_delay[37:22]
//  m_*     | out | tdata: status[0] fired_task[3:1]; tuser: fired; tlast: last
//
// A tick walks the slots one per cycle while no output stall holds the walk;
// the RAM read is registered, so each slot is evaluated from registered read data.
// Create, suspend, resume and delete go from idle through the response state.
// Reset clears the present and resumed flags and the control state; period and
// countdown live in RAM, and a slot's entry is written by create before it is used.
// A stalled output holds the walk when a second firing slot needs a beat out.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, task_index, period, first_delay
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status, fired_task
    output logic        m_tuser,   // fired
    output logic        m_tlast
);

    ptts_pkg::state_t state_reg, state_next;

    logic [ptts_pkg::MODE_W-1:0] in_mode;
    logic [ptts_pkg::IDX_W-1:0]  in_idx;
    logic [ptts_pkg::TIME_W-1:0] in_period;
    logic [ptts_pkg::TIME_W-1:0] in_delay;
    logic [ptts_pkg::SLOT_W-1:0] in_slot;
    logic                        in_valid_idx;
    logic                        in_accept;
    logic                        create_ok;

    logic [ptts_pkg::TASK_SLOTS-1:0] present_reg;
    logic [ptts_pkg::TASK_SLOTS-1:0] resumed_reg;
    logic                            status_reg;

    logic [ptts_pkg::CNT_W-1:0]  rd_idx_reg;
    logic                        eval_vld_reg;
    logic [ptts_pkg::SLOT_W-1:0] eval_idx_reg;
    logic                        pend_vld_reg;
    logic [ptts_pkg::IDX_W-1:0]  pend_idx_reg;
    logic [ptts_pkg::REP_W-1:0]  rep_cnt_reg;

    logic                        out_vld_reg;
    logic                        out_status_reg;
    logic                        out_fired_reg;
    logic [ptts_pkg::IDX_W-1:0]  out_task_reg;
    logic                        out_last_reg;

    logic                         ram_we;
    logic [ptts_pkg::SLOT_W-1:0]  ram_waddr;
    logic [ptts_pkg::ENTRY_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [ptts_pkg::ENTRY_W-1:0] ram_rdata;

    logic                        ev_active;
    logic                        ev_fire;
    logic                        ev_report;
    logic [ptts_pkg::TIME_W-1:0] ev_cd;
    logic [ptts_pkg::TIME_W-1:0] ev_per;
    logic                        out_can;
    logic                        stall;
    logic                        issue;
    logic                        eval_done;

    logic                        push;
    logic                        push_status;
    logic                        push_fired;
    logic [ptts_pkg::IDX_W-1:0]  push_task;
    logic                        push_last;

    assign in_mode      = s_tdata[2:0];
    assign in_idx       = s_tdata[5:3];
    assign in_period    = s_tdata[21:6];
    assign in_delay     = s_tdata[37:22];
    assign in_slot      = ptts_pkg::SLOT_W'(in_idx);
    assign in_valid_idx = 32'(in_idx) < ptts_pkg::TASK_SLOTS;
    assign in_accept    = s_tvalid && s_tready;
    assign create_ok    = in_valid_idx && !present_reg[in_slot];

    // countdown in the low half of an entry, period in the high half
    assign ev_cd     = ram_rdata[ptts_pkg::TIME_W-1:0];
    assign ev_per    = ram_rdata[ptts_pkg::ENTRY_W-1:ptts_pkg::TIME_W];
    assign ev_active = eval_vld_reg && present_reg[eval_idx_reg] && resumed_reg[eval_idx_reg];
    assign ev_fire   = ev_active && (ev_cd == '0);
    assign ev_report = ev_fire && (rep_cnt_reg < ptts_pkg::REP_W'(ptts_pkg::MAX_RESULTS));
    assign out_can   = !out_vld_reg || m_tready;
    // a new firing slot pushes the held one out; wait if the output is full
    assign stall     = ev_report && pend_vld_reg && !out_can;
    assign issue     = (state_reg == ptts_pkg::ST_WALK) && !stall
                       && (rd_idx_reg < ptts_pkg::CNT_W'(ptts_pkg::TASK_SLOTS));
    assign eval_done = eval_vld_reg && !stall
                       && (eval_idx_reg == ptts_pkg::SLOT_W'(ptts_pkg::TASK_SLOTS - 1));

    ptts_ram #(
        .WIDTH (ptts_pkg::ENTRY_W),
        .DEPTH (ptts_pkg::TASK_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[ptts_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_re = issue;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (ptts_pkg::mode_t'(in_mode) == ptts_pkg::MODE_TICK)
                    begin
                        state_next = ptts_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = ptts_pkg::ST_RESP;
                    end
                end
            end
            ptts_pkg::ST_WALK:
            begin
                if (eval_done)
                begin
                    state_next = ptts_pkg::ST_FINISH;
                end
            end
            ptts_pkg::ST_FINISH,
            ptts_pkg::ST_RESP:
            begin
                if (out_can)
                begin
                    state_next = ptts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptts_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready    = 1'b0;
        push        = 1'b0;
        push_status = 1'b0;
        push_fired  = 1'b0;
        push_task   = '0;
        push_last   = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = eval_idx_reg;
        ram_wdata   = {ev_per, ev_cd - ptts_pkg::TIME_W'(1)};
        case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_waddr = in_slot;
                ram_wdata = {in_period, in_delay};
                ram_we    = in_accept && create_ok
                            && (ptts_pkg::mode_t'(in_mode) == ptts_pkg::MODE_CREATE);
            end
            ptts_pkg::ST_WALK:
            begin
                push       = ev_report && pend_vld_reg && out_can;
                push_fired = 1'b1;
                push_task  = pend_idx_reg;
                push_last  = 1'b0;
                ram_we     = ev_active && !stall;
                if (ev_fire)
                begin
                    ram_wdata = {ev_per, ev_per - ptts_pkg::TIME_W'(1)};
                end
            end
            ptts_pkg::ST_FINISH:
            begin
                push       = out_can;
                push_fired = pend_vld_reg;
                push_task  = pend_vld_reg ? pend_idx_reg : '0;
            end
            ptts_pkg::ST_RESP:
            begin
                push        = out_can;
                push_status = status_reg;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ptts_pkg::ST_IDLE;
            present_reg  <= '0;
            resumed_reg  <= '0;
            eval_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            rd_idx_reg   <= '0;
            rep_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (push)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (in_accept)
            begin
                rd_idx_reg   <= '0;
                eval_vld_reg <= 1'b0;
                pend_vld_reg <= 1'b0;
                rep_cnt_reg  <= '0;
                case (ptts_pkg::mode_t'(in_mode))
                    ptts_pkg::MODE_CREATE:
                    begin
                        if (create_ok)
                        begin
                            present_reg[in_slot] <= 1'b1;
                            resumed_reg[in_slot] <= 1'b1;
                        end
                    end
                    ptts_pkg::MODE_SUSPEND:
                    begin
                        if (in_valid_idx)
                        begin
                            resumed_reg[in_slot] <= 1'b0;
                        end
                    end
                    ptts_pkg::MODE_RESUME:
                    begin
                        if (in_valid_idx)
                        begin
                            resumed_reg[in_slot] <= 1'b1;
                        end
                    end
                    ptts_pkg::MODE_DELETE:
                    begin
                        if (in_valid_idx)
                        begin
                            present_reg[in_slot] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if ((state_reg == ptts_pkg::ST_WALK) && !stall)
            begin
                eval_vld_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + ptts_pkg::CNT_W'(1);
                end
                if (ev_report)
                begin
                    pend_vld_reg <= 1'b1;
                    rep_cnt_reg  <= rep_cnt_reg + ptts_pkg::REP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg <= (ptts_pkg::mode_t'(in_mode) == ptts_pkg::MODE_CREATE) && !create_ok;
        end
        if (issue)
        begin
            eval_idx_reg <= rd_idx_reg[ptts_pkg::SLOT_W-1:0];
        end
        if ((state_reg == ptts_pkg::ST_WALK) && !stall && ev_report)
        begin
            pend_idx_reg <= ptts_pkg::IDX_W'(eval_idx_reg);
        end
        if (push)
        begin
            out_status_reg <= push_status;
            out_fired_reg  <= push_fired;
            out_task_reg   <= push_task;
            out_last_reg   <= push_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, out_task_reg, out_status_reg};
    assign m_tuser  = out_fired_reg;
    assign m_tlast  = out_last_reg;

    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg <= ptts_pkg::REP_W'(ptts_pkg::MAX_RESULTS))
        else $error("more results counted than a tick may report");

    a_eval_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ptts_pkg::ST_WALK) |-> !eval_vld_reg)
        else $error("slot evaluation outside of a walk");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptts_pkg::ST_IDLE && out_vld_reg) |-> out_last_reg)
        else $error("beat left without last while idle");

    a_no_late_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptts_pkg::ST_FINISH || state_reg == ptts_pkg::ST_RESP) |-> !ram_we)
        else $error("slot RAM written after the walk ended");

endmodule

/* sv/ptts_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* verif/tick_schedule_checker.sv */
// Stream checker: predicts the scheduler's firing reports and compares every output beat.
`timescale 1ns / 1ps

module tick_schedule_checker
    import ptts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, task_index, period, first_delay
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // status, fired_task
    input  logic        m_tuser,   // fired
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          firings
);

    typedef struct packed {
        logic             status;
        logic             fired;
        logic [IDX_W-1:0] fired_task;
        logic             last;
    } sched_report_t;

    sched_report_t    report_q[$];
    logic             slot_live[TASK_SLOTS];
    logic             slot_running[TASK_SLOTS];
    logic [TIME_W-1:0] slot_reload[TASK_SLOTS];
    logic [TIME_W-1:0] slot_count[TASK_SLOTS];
    int               mismatches;
    int               fire_total;

    // Apply one command beat to the shadow table and queue the reports it causes.
    task automatic apply_command(input logic [39:0] beat);
        logic [MODE_W-1:0]     op;
        logic [IDX_W-1:0]      idx;
        logic [TIME_W-1:0]     per;
        logic [TIME_W-1:0]     dly;
        logic [TASK_SLOTS-1:0] fire_mask;
        int                    shown;
        int                    reported;
        sched_report_t         rep;
        op   = beat[2:0];
        idx  = beat[5:3];
        per  = beat[21:6];
        dly  = beat[37:22];
        rep  = '0;
        rep.last = 1'b1;
        case (op)
            MODE_TICK:
            begin
                fire_mask = '0;
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (slot_live[i] && slot_running[i])
                    begin
                        if (slot_count[i] == '0)
                        begin
                            fire_mask[i]  = 1'b1;
                            slot_count[i] = slot_reload[i] - 1'b1;
                        end
                        else
                        begin
                            slot_count[i] = slot_count[i] - 1'b1;
                        end
                    end
                end
                shown = $countones(fire_mask);
                if (shown > MAX_RESULTS)
                    shown = MAX_RESULTS;
                reported = 0;
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (fire_mask[i] && reported < shown)
                    begin
                        rep.status     = 1'b0;
                        rep.fired      = 1'b1;
                        rep.fired_task = IDX_W'(i);
                        rep.last       = (reported == shown - 1);
                        report_q.push_back(rep);
                        reported++;
                    end
                end
                // quiet tick still answers with one empty report
                if (shown == 0)
                    report_q.push_back(rep);
                fire_total += shown;
            end
            MODE_CREATE:
            begin
                if (idx >= TASK_SLOTS || slot_live[idx])
                begin
                    rep.status = 1'b1;
                end
                else
                begin
                    slot_live[idx]    = 1'b1;
                    slot_running[idx] = 1'b1;
                    slot_reload[idx]  = per;
                    slot_count[idx]   = dly;
                end
            end
            MODE_SUSPEND:
            begin
                if (idx < TASK_SLOTS)
                    slot_running[idx] = 1'b0;
            end
            MODE_RESUME:
            begin
                if (idx < TASK_SLOTS)
                    slot_running[idx] = 1'b1;
            end
            MODE_DELETE:
            begin
                if (idx < TASK_SLOTS)
                    slot_live[idx] = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (op != MODE_TICK)
            report_q.push_back(rep);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                slot_live[i]    = 1'b0;
                slot_running[i] = 1'b0;
            end
            report_q.delete();
            mismatches = 0;
            fire_total = 0;
            fail_count <= 0;
            pending    <= 0;
            firings    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_command(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result beat with nothing pending: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (m_tdata[0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tuser !== want.fired)
                    begin
                        $error("fired: expected %0d, got %0d", want.fired, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[3:1] !== want.fired_task)
                    begin
                        $error("fired_task: expected %0d, got %0d", want.fired_task,
                               m_tdata[3:1]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= report_q.size();
            firings    <= fire_total;
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top: drives scheduler commands with random pacing and reports the verdict.
`timescale 1ns / 1ps

module tb;
    import ptts_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RESERVED_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESERVED_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RESERVED_HI  = 3'd7;
    localparam int RANDOM_COMMANDS = 205;
    localparam int SENDER   = 0;
    localparam int RECEIVER = 1;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // mode[2:0] task_index[5:3] period[21:6] first_delay[37:22]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // status[0] fired_task[3:1]
    logic        m_tuser;   // fired
    logic        m_tlast;

    int fail_count;
    int pending;
    int firings;
    int quiet_left[2] = '{0, 0};
    int beats_sent    = 0;
    int ticks_sent    = 0;

    periodic_task_tick_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tick_schedule_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .firings    (firings)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("periodic_task_tick_scheduler verification failed");
        $finish;
    end

    // Gap before the next beat on one side; occasional runs of back-to-back beats.
    function automatic int next_gap(input int side);
        int gap;
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            quiet_left[side] = $urandom_range(10, 30);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 12);
        end
        return gap;
    endfunction

    task automatic send_command(input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly);
        int gap;
        gap = next_gap(SENDER);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dly, per, idx, op};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
        if (op == MODE_TICK)
            ticks_sent++;
    endtask

    // result side: random stalls between beats
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = next_gap(RECEIVER);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, flag changes on empty slots
        send_command(MODE_TICK, 3'd0, 16'd0, 16'd0);
        send_command(MODE_SUSPEND, 3'd2, 16'd0, 16'd0);
        send_command(MODE_RESUME, 3'd5, 16'd0, 16'd0);
        send_command(MODE_DELETE, 3'd6, 16'd0, 16'd0);
        // fill every slot, one refused create, then all eight fire on one tick
        send_command(MODE_CREATE, 3'd0, 16'd1, 16'd0);
        send_command(MODE_CREATE, 3'd0, 16'd5, 16'd5);
        send_command(MODE_CREATE, 3'd1, 16'd1, 16'd0);
        send_command(MODE_CREATE, 3'd2, 16'd2, 16'd0);
        send_command(MODE_CREATE, 3'd3, 16'hFFFF, 16'd0);
        send_command(MODE_CREATE, 3'd4, 16'd1, 16'd0);
        send_command(MODE_CREATE, 3'd5, 16'd1, 16'd0);
        send_command(MODE_CREATE, 3'd6, 16'd1, 16'd0);
        send_command(MODE_CREATE, 3'd7, 16'd0, 16'd0);
        send_command(MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
        send_command(MODE_SUSPEND, 3'd4, 16'd0, 16'd0);
        send_command(MODE_TICK, 3'd0, 16'd0, 16'd0);
        send_command(MODE_RESUME, 3'd4, 16'd0, 16'd0);
        send_command(MODE_DELETE, 3'd3, 16'd0, 16'd0);
        send_command(MODE_CREATE, 3'd3, 16'hFFFF, 16'hFFFF);
        send_command(MODE_TICK, 3'd0, 16'd0, 16'd0);
        send_command(MODE_RESERVED_LO, 3'($urandom), 16'($urandom), 16'($urandom));
        send_command(MODE_RESERVED_MID, 3'($urandom), 16'($urandom), 16'($urandom));
        send_command(MODE_RESERVED_HI, 3'($urandom), 16'($urandom), 16'($urandom));
        send_command(MODE_DELETE, 3'd7, 16'd0, 16'd0);
        send_command(MODE_TICK, 3'd0, 16'd0, 16'd0);

        // short periods and delays most of the time so slots keep firing
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_command(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_command(MODE_CREATE, 3'($urandom), 16'($urandom), 16'($urandom));
                else
                    send_command(MODE_CREATE, 3'($urandom), 16'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 8)));
            end
            else if (pick < 78)
                send_command(MODE_SUSPEND, 3'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 86)
                send_command(MODE_RESUME, 3'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 96)
                send_command(MODE_DELETE, 3'($urandom), 16'($urandom), 16'($urandom));
            else
                send_command(3'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI)),
                             3'($urandom), 16'($urandom), 16'($urandom));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4 * TASK_SLOTS + 16) @(posedge clk);

        $display("%0d command beats driven (%0d ticks), %0d task firings checked",
                 beats_sent, ticks_sent, firings);
        if (fail_count == 0 && pending == 0)
            $display("periodic_task_tick_scheduler verification clean");
        else
            $display("periodic_task_tick_scheduler verification failed");
        $finish;
    end

endmodule
